// ===== rtl/sbsm_pkg.sv =====
// Shared types, codes and constants for the serial bank switch mapper.
// No dependencies; every rtl file refers to it by scoped names.
package sbsm_pkg;

   localparam int RAM_BYTES = 8192;
   localparam int RAM_AW    = $clog2(RAM_BYTES);
   localparam int REM_STEPS = 5;

   // Request kinds carried on req_tuser
   localparam logic [1:0] REQ_CPU_RD = 2'd0;
   localparam logic [1:0] REQ_CPU_WR = 2'd1;
   localparam logic [1:0] REQ_PPU_RD = 2'd2;
   localparam logic [1:0] REQ_PPU_WR = 2'd3;

   // Result targets carried on rsp_tuser
   localparam logic [1:0] TGT_INTERNAL = 2'd0;
   localparam logic [1:0] TGT_PRG_RD   = 2'd1;
   localparam logic [1:0] TGT_PAT_RD   = 2'd2;
   localparam logic [1:0] TGT_PAT_WR   = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_PRG_COUNT = 3'd0;
   localparam logic [2:0] CSR_CHR_COUNT = 3'd1;
   localparam logic [2:0] CSR_CHR_PRES  = 3'd2;
   localparam logic [2:0] CSR_CHR_LEN   = 3'd3;
   localparam logic [2:0] CSR_CHR_WR    = 3'd4;

   localparam logic [4:0]  CTRL_RESET_VAL  = 5'h0C;
   localparam logic [2:0]  SERIAL_LAST     = 3'd4;
   localparam logic [15:0] ADDR_CTRL_TOP   = 16'h9FFF;
   localparam logic [15:0] ADDR_CHR_LO_TOP = 16'hBFFF;
   localparam logic [15:0] ADDR_CHR_HI_TOP = 16'hDFFF;
   localparam logic [15:0] ADDR_PPU_LO_TOP = 16'h0FFF;
   localparam logic [7:0]  RAM_OFF_DATA    = 8'hFF;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BUSY
   } state_type;

   typedef struct packed {
      logic       done;
      logic [4:0] rem;
   } rem_status_type;

   function automatic logic [4:0] clamp_count(input logic [4:0] n, input logic [4:0] maxv);
      logic [4:0] r;
      if (n == 5'd0) begin
         r = 5'd1;
      end else if (n > maxv) begin
         r = maxv;
      end else begin
         r = n;
      end
      return r;
   endfunction

endpackage

// ===== rtl/sbsm_wram.sv =====
// 8 KB work RAM with a zeroing sweep after reset and registered read data.
// Depends on sbsm_pkg for the depth.
module sbsm_wram (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       access_en,
   input  logic                       access_we,
   input  logic [sbsm_pkg::RAM_AW-1:0] access_addr,
   input  logic [7:0]                 access_wdata,
   output logic [7:0]                 access_rdata,
   output logic                       ready
);

   logic [7:0] mem [sbsm_pkg::RAM_BYTES];
   logic [7:0] rdata_ff;
   logic       clear_busy_ff, clear_busy_in;
   logic [sbsm_pkg::RAM_AW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clear_busy_in = clear_busy_ff && (clr_addr_ff != {sbsm_pkg::RAM_AW{1'b1}});
      clr_addr_in   = clear_busy_ff ? clr_addr_ff + 1'b1 : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clr_addr_ff] <= 8'd0;
      end else if (access_we) begin
         mem[access_addr] <= access_wdata;
      end
      if (access_en) begin
         rdata_ff <= mem[access_addr];
      end
   end

   assign access_rdata = rdata_ff;
   assign ready        = !clear_busy_ff;

endmodule

// ===== rtl/sbsm_rem_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle over a five-bit dividend.
// Depends on sbsm_pkg for the step count and the status struct.
module sbsm_rem_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [4:0]               dividend,
   input  logic [5:0]               divisor,
   output sbsm_pkg::rem_status_type status
);

   logic [4:0] quo_ff, quo_in;
   logic [5:0] div_ff, div_in;
   logic [5:0] part_ff, part_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [5:0] trial;

   always_comb begin
      trial   = {part_ff[4:0], quo_ff[4]};
      quo_in  = quo_ff;
      div_in  = div_ff;
      part_in = part_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         quo_in  = dividend;
         div_in  = divisor;
         part_in = '0;
         cnt_in  = 3'(sbsm_pkg::REM_STEPS);
      end else if (cnt_ff != 3'd0) begin
         quo_in  = {quo_ff[3:0], 1'b0};
         part_in = (trial >= div_ff) ? trial - div_ff : trial;
         cnt_in  = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff  <= '0;
         div_ff  <= 6'd1;
         part_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         quo_ff  <= quo_in;
         div_ff  <= div_in;
         part_ff <= part_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign status.done = (cnt_ff == 3'd0);
   assign status.rem  = part_ff[4:0];

`ifndef NO_ASSERTIONS
   a_part_below_div: assert property (@(posedge clock) disable iff (reset)
      (div_ff != 6'd0) |-> (part_ff < div_ff))
      else $error("remainder not below divisor");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> !status.done)
      else $error("unit done right after start");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(sbsm_pkg::REM_STEPS))
      else $error("step count out of range");
`endif

endmodule

// ===== rtl/serial_bank_switch_mapper.sv =====
// Serial bank switch mapper: a bus access is accepted, its bank taken modulo the bank count
// in the shared remainder unit, and the result registered once the run ends and the output
// slot is free. A new access is taken only after that, behind the 5-step remainder loop.
// Reset is synchronous; afterwards the 8192-byte work RAM is zeroed, and no access is
// accepted until that sweep ends (configuration writes are taken throughout).
module serial_bank_switch_mapper #(
   parameter int MAX_PRG_BANKS = 16,
   parameter int MAX_CHR_BANKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // bus_address[15:0], bus_data[23:16]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // mem_address[17:0], read_data[25:18],
                                   // write_data[33:26], mirror_mode[35:34], zero
   output logic [1:0]  rsp_tuser,  // target[1:0]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_wdata
);

   sbsm_pkg::state_type state_ff, state_in;

   logic [4:0]  prg_count_ff, prg_count_in;
   logic [4:0]  chr_count_ff, chr_count_in;
   logic        chr_pres_ff, chr_pres_in;
   logic [17:0] chr_len_ff, chr_len_in;
   logic        chr_wr_ff, chr_wr_in;

   logic [4:0]  shift_ff, shift_in;
   logic [2:0]  count_ff, count_in;
   logic [4:0]  control_ff, control_in;
   logic [4:0]  chr_lo_ff, chr_lo_in;
   logic [4:0]  chr_hi_ff, chr_hi_in;
   logic [4:0]  prog_bank_ff, prog_bank_in;

   logic [1:0]  item_kind_ff, item_kind_in;
   logic [15:0] item_addr_ff, item_addr_in;
   logic [7:0]  item_data_ff, item_data_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_target_ff, out_target_in;
   logic [17:0] out_maddr_ff, out_maddr_in;
   logic [7:0]  out_rdata_ff, out_rdata_in;
   logic [7:0]  out_wdata_ff, out_wdata_in;
   logic [1:0]  out_mirror_ff, out_mirror_in;

   logic        accept, ready_int, load_out, out_free, wram_ready;
   logic [1:0]  req_kind;
   logic [15:0] req_addr;
   logic [7:0]  req_data;
   logic        req_in_ram, ram_on, item_in_ram;
   logic [7:0]  wram_rdata;
   logic [4:0]  prg_n, chr_n, prg_pairs;
   logic [4:0]  rem_dividend;
   logic [5:0]  rem_divisor;
   logic [17:0] prg_off, chr_off;
   logic [3:0]  prg_last;
   sbsm_pkg::rem_status_type rem_stat;

   assign req_kind   = req_tuser;
   assign req_addr   = req_tdata[15:0];
   assign req_data   = req_tdata[23:16];
   assign accept     = req_tvalid && ready_int;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign ram_on     = !prog_bank_ff[4];
   assign req_in_ram = (req_addr[15:13] == 3'b011);
   assign item_in_ram = (item_addr_ff[15:13] == 3'b011);

   assign prg_n     = sbsm_pkg::clamp_count(prg_count_ff, 5'(MAX_PRG_BANKS));
   assign chr_n     = sbsm_pkg::clamp_count(chr_count_ff, 5'(MAX_CHR_BANKS));
   assign prg_pairs = (prg_n[4:1] == 4'd0) ? 5'd1 : {1'b0, prg_n[4:1]};
   assign prg_last  = 4'(prg_n - 5'd1);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbsm_pkg::ST_CLEAR: if (wram_ready) state_in = sbsm_pkg::ST_IDLE;
         sbsm_pkg::ST_IDLE:  if (req_tvalid) state_in = sbsm_pkg::ST_BUSY;
         sbsm_pkg::ST_BUSY:  if (rem_stat.done && out_free) state_in = sbsm_pkg::ST_IDLE;
         default:            state_in = sbsm_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      ready_int = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         sbsm_pkg::ST_IDLE: ready_int = 1'b1;
         sbsm_pkg::ST_BUSY: load_out  = rem_stat.done && out_free;
         default: begin
            ready_int = 1'b0;
            load_out  = 1'b0;
         end
      endcase
   end

   // Configuration registers
   always_comb begin
      prg_count_in = prg_count_ff;
      chr_count_in = chr_count_ff;
      chr_pres_in  = chr_pres_ff;
      chr_len_in   = chr_len_ff;
      chr_wr_in    = chr_wr_ff;
      if (csr_we) begin
         case (csr_index)
            sbsm_pkg::CSR_PRG_COUNT: prg_count_in = csr_wdata[4:0];
            sbsm_pkg::CSR_CHR_COUNT: chr_count_in = csr_wdata[4:0];
            sbsm_pkg::CSR_CHR_PRES:  chr_pres_in  = csr_wdata[0];
            sbsm_pkg::CSR_CHR_LEN:   chr_len_in   = csr_wdata;
            sbsm_pkg::CSR_CHR_WR:    chr_wr_in    = csr_wdata[0];
            default:                 chr_wr_in    = chr_wr_ff;
         endcase
      end
   end

   // Serial loader
   always_comb begin
      logic [4:0] shift_next;
      shift_next  = {req_data[0], shift_ff[4:1]};
      shift_in    = shift_ff;
      count_in    = count_ff;
      control_in  = control_ff;
      chr_lo_in   = chr_lo_ff;
      chr_hi_in   = chr_hi_ff;
      prog_bank_in = prog_bank_ff;
      if (accept && req_kind == sbsm_pkg::REQ_CPU_WR && req_addr[15]) begin
         if (req_data[7]) begin
            shift_in   = '0;
            count_in   = '0;
            control_in = control_ff | sbsm_pkg::CTRL_RESET_VAL;
         end else if (count_ff == sbsm_pkg::SERIAL_LAST) begin
            shift_in = '0;
            count_in = '0;
            if (req_addr <= sbsm_pkg::ADDR_CTRL_TOP) begin
               control_in = shift_next;
            end else if (req_addr <= sbsm_pkg::ADDR_CHR_LO_TOP) begin
               chr_lo_in = shift_next;
            end else if (req_addr <= sbsm_pkg::ADDR_CHR_HI_TOP) begin
               chr_hi_in = shift_next;
            end else begin
               prog_bank_in = shift_next;
            end
         end else begin
            shift_in = shift_next;
            count_in = count_ff + 3'd1;
         end
      end
   end

   // Remainder operands
   always_comb begin
      if (!req_kind[1]) begin
         if (!control_ff[3]) begin
            rem_dividend = {2'b00, prog_bank_ff[3:1]};
            rem_divisor  = {1'b0, prg_pairs};
         end else begin
            rem_dividend = {1'b0, prog_bank_ff[3:0]};
            rem_divisor  = {1'b0, prg_n};
         end
      end else if (!control_ff[4]) begin
         rem_dividend = {1'b0, chr_lo_ff[4:1]};
         rem_divisor  = {1'b0, chr_n};
      end else begin
         rem_dividend = (req_addr <= sbsm_pkg::ADDR_PPU_LO_TOP) ? chr_lo_ff : chr_hi_ff;
         rem_divisor  = {chr_n, 1'b0};
      end
   end

   sbsm_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (rem_dividend),
      .divisor  (rem_divisor),
      .status   (rem_stat)
   );

   sbsm_wram u_wram (
      .clock        (clock),
      .reset        (reset),
      .access_en    (accept),
      .access_we    (accept && req_kind == sbsm_pkg::REQ_CPU_WR && req_in_ram && ram_on),
      .access_addr  (req_addr[sbsm_pkg::RAM_AW-1:0]),
      .access_wdata (req_data),
      .access_rdata (wram_rdata),
      .ready        (wram_ready)
   );

   // Offsets from the remainder
   always_comb begin
      case (control_ff[3:2])
         2'd2: prg_off = item_addr_ff[14] ? {rem_stat.rem[3:0], item_addr_ff[13:0]}
                                          : {4'd0, item_addr_ff[13:0]};
         2'd3: prg_off = item_addr_ff[14] ? {prg_last, item_addr_ff[13:0]}
                                          : {rem_stat.rem[3:0], item_addr_ff[13:0]};
         default: prg_off = {rem_stat.rem[2:0], item_addr_ff[14:0]};
      endcase
      if (!control_ff[4]) begin
         chr_off = {1'b0, rem_stat.rem[3:0], item_addr_ff[12:0]};
      end else begin
         chr_off = {1'b0, rem_stat.rem, item_addr_ff[11:0]};
      end
   end

   // Item and result registers
   always_comb begin
      item_kind_in = accept ? req_kind : item_kind_ff;
      item_addr_in = accept ? req_addr : item_addr_ff;
      item_data_in = accept ? req_data : item_data_ff;

      out_valid_in  = load_out ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_target_in = out_target_ff;
      out_maddr_in  = out_maddr_ff;
      out_rdata_in  = out_rdata_ff;
      out_wdata_in  = out_wdata_ff;
      out_mirror_in = out_mirror_ff;
      if (load_out) begin
         out_target_in = sbsm_pkg::TGT_INTERNAL;
         out_maddr_in  = '0;
         out_rdata_in  = '0;
         out_wdata_in  = '0;
         out_mirror_in = control_ff[1:0];
         case (item_kind_ff)
            sbsm_pkg::REQ_CPU_RD: begin
               if (item_in_ram) begin
                  out_rdata_in = ram_on ? wram_rdata : sbsm_pkg::RAM_OFF_DATA;
               end else if (item_addr_ff[15]) begin
                  out_target_in = sbsm_pkg::TGT_PRG_RD;
                  out_maddr_in  = prg_off;
               end
            end
            sbsm_pkg::REQ_PPU_RD: begin
               if (chr_pres_ff && chr_off < chr_len_ff) begin
                  out_target_in = sbsm_pkg::TGT_PAT_RD;
                  out_maddr_in  = chr_off;
               end
            end
            sbsm_pkg::REQ_PPU_WR: begin
               if (chr_pres_ff && chr_wr_ff && chr_off < chr_len_ff) begin
                  out_target_in = sbsm_pkg::TGT_PAT_WR;
                  out_maddr_in  = chr_off;
                  out_wdata_in  = item_data_ff;
               end
            end
            default: out_target_in = sbsm_pkg::TGT_INTERNAL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbsm_pkg::ST_CLEAR;
         prg_count_ff <= 5'd16;
         chr_count_ff <= 5'd1;
         chr_pres_ff  <= 1'b1;
         chr_len_ff   <= 18'd8192;
         chr_wr_ff    <= 1'b0;
         shift_ff     <= '0;
         count_ff     <= '0;
         control_ff   <= sbsm_pkg::CTRL_RESET_VAL;
         chr_lo_ff    <= '0;
         chr_hi_ff    <= '0;
         prog_bank_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prg_count_ff <= prg_count_in;
         chr_count_ff <= chr_count_in;
         chr_pres_ff  <= chr_pres_in;
         chr_len_ff   <= chr_len_in;
         chr_wr_ff    <= chr_wr_in;
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         control_ff   <= control_in;
         chr_lo_ff    <= chr_lo_in;
         chr_hi_ff    <= chr_hi_in;
         prog_bank_ff <= prog_bank_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_kind_ff  <= item_kind_in;
      item_addr_ff  <= item_addr_in;
      item_data_ff  <= item_data_in;
      out_target_ff <= out_target_in;
      out_maddr_ff  <= out_maddr_in;
      out_rdata_ff  <= out_rdata_in;
      out_wdata_ff  <= out_wdata_in;
      out_mirror_ff <= out_mirror_in;
   end

   assign req_tready = ready_int;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_target_ff;
   assign rsp_tdata  = {4'd0, out_mirror_ff, out_wdata_ff, out_rdata_ff, out_maddr_ff};

`ifndef NO_ASSERTIONS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == sbsm_pkg::ST_BUSY))
      else $error("accepted word did not start the sequencer");
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == sbsm_pkg::ST_BUSY && rem_stat.done))
      else $error("result word raised outside a finished run");
   a_serial_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sbsm_pkg::SERIAL_LAST)
      else $error("serial count beyond last bit");
`endif

endmodule

// ===== dv/serial_bank_switch_mapper_tb.sv =====
// Self-checking bench for serial_bank_switch_mapper: drives bus accesses and csr writes,
// predicts each translated word with a shadow of the banking state and checks it in order.
// Depends on sbsm_pkg and the mapper RTL only.
`timescale 1ns / 100ps

module serial_bank_switch_mapper_tb;

   localparam int MAX_PRG    = 16;
   localparam int MAX_CHR    = 16;
   localparam int LONG_HOLD  = 400;
   localparam int PHASES     = 8;
   localparam int PHASE_SIZE = 200;
   localparam int RUN_LIMIT  = 600000;

   typedef struct packed {
      logic [1:0]  target;
      logic [17:0] mem_address;
      logic [7:0]  read_data;
      logic [7:0]  write_data;
      logic [1:0]  mirror_mode;
   } bus_result_type;

   class access_translator_type;
      logic [4:0]  prg_count;
      logic [4:0]  chr_count;
      logic        chr_here;
      logic        chr_ram;
      logic [17:0] chr_bytes;
      logic [4:0]  shift_bits;
      logic [2:0]  shift_count;
      logic [4:0]  ctrl;
      logic [4:0]  pat_lo;
      logic [4:0]  pat_hi;
      logic [4:0]  prog_bank;
      logic [7:0]  work_ram [sbsm_pkg::RAM_BYTES];
      bus_result_type pending_results [$];
      int          mismatches;

      function new();
         prg_count   = 5'd16;
         chr_count   = 5'd1;
         chr_here    = 1'b1;
         chr_bytes   = 18'd8192;
         chr_ram     = 1'b0;
         shift_bits  = '0;
         shift_count = '0;
         ctrl        = sbsm_pkg::CTRL_RESET_VAL;
         pat_lo      = '0;
         pat_hi      = '0;
         prog_bank   = '0;
         foreach (work_ram[i]) work_ram[i] = 8'h00;
         mismatches  = 0;
      endfunction

      function void set_reg(input logic [2:0] idx, input logic [17:0] val);
         case (idx)
            sbsm_pkg::CSR_PRG_COUNT: prg_count = val[4:0];
            sbsm_pkg::CSR_CHR_COUNT: chr_count = val[4:0];
            sbsm_pkg::CSR_CHR_PRES:  chr_here  = val[0];
            sbsm_pkg::CSR_CHR_LEN:   chr_bytes = val;
            sbsm_pkg::CSR_CHR_WR:    chr_ram   = val[0];
            default: ;
         endcase
      endfunction

      function int bank_total(input logic [4:0] n, input int maxv);
         if (n == 5'd0) return 1;
         return (int'(n) > maxv) ? maxv : int'(n);
      endfunction

      function int prg_offset(input logic [15:0] addr);
         int n;
         int pairs;
         int bank;
         n = bank_total(prg_count, MAX_PRG);
         bank = int'(prog_bank[3:0]);
         case (ctrl[3:2])
            2'd0, 2'd1: begin
               pairs = (n / 2 > 0) ? n / 2 : 1;
               return ((bank >> 1) % pairs) * 32'h8000 + int'(addr[14:0]);
            end
            2'd2: begin
               if (addr <= 16'hBFFF) return int'(addr[13:0]);
               return (bank % n) * 32'h4000 + int'(addr[13:0]);
            end
            default: begin
               if (addr <= 16'hBFFF) return (bank % n) * 32'h4000 + int'(addr[13:0]);
               return (n - 1) * 32'h4000 + int'(addr[13:0]);
            end
         endcase
      endfunction

      function int chr_offset(input logic [15:0] addr);
         int n;
         n = bank_total(chr_count, MAX_CHR);
         if (!ctrl[4]) return ((int'(pat_lo) >> 1) % n) * 32'h2000 + int'(addr[12:0]);
         if (addr <= sbsm_pkg::ADDR_PPU_LO_TOP)
            return (int'(pat_lo) % (2 * n)) * 32'h1000 + int'(addr[11:0]);
         return (int'(pat_hi) % (2 * n)) * 32'h1000 + int'(addr[11:0]);
      endfunction

      function void shift_in(input logic [15:0] addr, input logic [7:0] data);
         if (data[7]) begin
            shift_bits  = '0;
            shift_count = '0;
            ctrl        = ctrl | sbsm_pkg::CTRL_RESET_VAL;
            return;
         end
         shift_bits  = {data[0], shift_bits[4:1]};
         shift_count = shift_count + 3'd1;
         if (shift_count > sbsm_pkg::SERIAL_LAST) begin
            if (addr <= sbsm_pkg::ADDR_CTRL_TOP) ctrl = shift_bits;
            else if (addr <= sbsm_pkg::ADDR_CHR_LO_TOP) pat_lo = shift_bits;
            else if (addr <= sbsm_pkg::ADDR_CHR_HI_TOP) pat_hi = shift_bits;
            else prog_bank = shift_bits;
            shift_bits  = '0;
            shift_count = '0;
         end
      endfunction

      function void take_access(input logic [1:0] kind, input logic [15:0] addr,
                                input logic [7:0] data);
         bus_result_type r;
         logic        ram_on;
         logic        in_ram;
         int          off;
         r      = '0;
         ram_on = !prog_bank[4];
         in_ram = addr >= 16'h6000 && addr <= 16'h7FFF;
         off    = chr_offset(addr);
         case (kind)
            sbsm_pkg::REQ_CPU_RD: begin
               if (in_ram) begin
                  r.read_data = ram_on ? work_ram[addr[12:0]] : sbsm_pkg::RAM_OFF_DATA;
               end else if (addr[15]) begin
                  r.target      = sbsm_pkg::TGT_PRG_RD;
                  r.mem_address = 18'(prg_offset(addr));
               end
            end
            sbsm_pkg::REQ_CPU_WR: begin
               if (in_ram) begin
                  if (ram_on) work_ram[addr[12:0]] = data;
               end else if (addr[15]) begin
                  shift_in(addr, data);
               end
            end
            sbsm_pkg::REQ_PPU_RD: begin
               if (chr_here && off < chr_bytes) begin
                  r.target      = sbsm_pkg::TGT_PAT_RD;
                  r.mem_address = 18'(off);
               end
            end
            default: begin
               if (chr_here && chr_ram && off < chr_bytes) begin
                  r.target      = sbsm_pkg::TGT_PAT_WR;
                  r.mem_address = 18'(off);
                  r.write_data  = data;
               end
            end
         endcase
         r.mirror_mode = ctrl[1:0];
         pending_results.push_back(r);
      endfunction

      task complain(input string what, input int got, input int want);
         $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
         mismatches++;
      endtask

      task match_result(input bus_result_type got);
         bus_result_type want;
         if (pending_results.size() == 0) begin
            complain("word with none outstanding", int'(got.target), 0);
            return;
         end
         want = pending_results.pop_front();
         if (got.target != want.target)
            complain("target", int'(got.target), int'(want.target));
         if (got.mem_address != want.mem_address)
            complain("mem_address", int'(got.mem_address), int'(want.mem_address));
         if (got.read_data != want.read_data)
            complain("read_data", int'(got.read_data), int'(want.read_data));
         if (got.write_data != want.write_data)
            complain("write_data", int'(got.write_data), int'(want.write_data));
         if (got.mirror_mode != want.mirror_mode)
            complain("mirror_mode", int'(got.mirror_mode), int'(want.mirror_mode));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // bus_address[15:0], bus_data[23:16]
   logic [1:0]  req_tuser  = '0;  // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // mem_address[17:0], read_data[25:18],
                                  // write_data[33:26], mirror_mode[35:34], zero
   logic [1:0]  rsp_tuser;        // target[1:0]
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [17:0] csr_wdata  = '0;

   access_translator_type shadow;
   bit  send_calm   = 1'b0;
   bit  take_calm   = 1'b0;
   bit  long_hold   = 1'b0;
   int  words_sent  = 0;
   int  cycle_count = 0;

   serial_bank_switch_mapper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap(input bit calm);
      if (calm) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] data);
      int gap;
      if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
      gap = pick_gap(send_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {data, addr};
      do @(posedge clock); while (!req_tready);
      shadow.take_access(kind, addr, data);
      if (!(kind == sbsm_pkg::REQ_CPU_WR && addr < 16'h6000)) words_sent++;
   endtask

   task automatic serial_load(input logic [15:0] addr, input logic [4:0] value);
      int i;
      for (i = 0; i < 5; i++)
         send_word(sbsm_pkg::REQ_CPU_WR,
                   (i == 4) ? addr : (16'h8000 | 16'($urandom_range(0, 16'h7FFF))),
                   {1'b0, 6'($urandom), value[i]});
   endtask

   task automatic random_burst();
      int          pick;
      int          n;
      int          zone;
      logic [15:0] a;
      logic [7:0]  d;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         serial_load(16'h8000 | 16'($urandom_range(0, 16'h7FFF)), 5'($urandom));
      end else if (pick < 30) begin
         n = $urandom_range(1, 4);
         repeat (n)
            send_word(sbsm_pkg::REQ_CPU_WR, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)),
                      8'($urandom_range(0, 127)));
         send_word(sbsm_pkg::REQ_CPU_WR, 16'h8000 | 16'($urandom_range(0, 16'h7FFF)),
                   8'h80 | 8'($urandom));
      end else if (pick < 60) begin
         zone = $urandom_range(0, 9);
         if (zone < 5) a = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
         else if (zone < 8) a = 16'h6000 | 16'($urandom_range(0, 16'h1FFF));
         else a = 16'($urandom);
         send_word(sbsm_pkg::REQ_CPU_RD, a, 8'($urandom));
      end else if (pick < 72) begin
         a = 16'h6000 | 16'($urandom_range(0, 16'h1FFF));
         d = 8'($urandom);
         send_word(sbsm_pkg::REQ_CPU_WR, a, d);
         send_word(sbsm_pkg::REQ_CPU_RD, a, 8'($urandom));
      end else if (pick < 95) begin
         a = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 16'h1FFF)) : 16'($urandom);
         send_word($urandom_range(0, 1) ? sbsm_pkg::REQ_PPU_WR : sbsm_pkg::REQ_PPU_RD,
                   a, 8'($urandom));
      end else begin
         send_word(2'($urandom), 16'($urandom), 8'($urandom));
      end
   endtask

   task automatic settle_outputs();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (shadow.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      shadow.set_reg(idx, val);
   endtask

   task automatic apply_setting(input logic [4:0] prg, input logic [4:0] chr, input logic pres,
                                input logic [17:0] len, input logic wr);
      write_reg(sbsm_pkg::CSR_PRG_COUNT, 18'(prg));
      write_reg(sbsm_pkg::CSR_CHR_COUNT, 18'(chr));
      write_reg(sbsm_pkg::CSR_CHR_PRES, 18'(pres));
      write_reg(sbsm_pkg::CSR_CHR_LEN, len);
      write_reg(sbsm_pkg::CSR_CHR_WR, 18'(wr));
   endtask

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : result_side
      int             stall;
      bus_result_type seen;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) take_calm = !take_calm;
         stall = pick_gap(take_calm);
         if (long_hold) begin
            stall     = LONG_HOLD;
            long_hold = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen.target      = rsp_tuser;
         seen.mem_address = rsp_tdata[17:0];
         seen.read_data   = rsp_tdata[25:18];
         seen.write_data  = rsp_tdata[33:26];
         seen.mirror_mode = rsp_tdata[35:34];
         shadow.match_result(seen);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int phase;
      shadow = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(sbsm_pkg::REQ_CPU_RD, 16'h0000, 8'h00);
      send_word(sbsm_pkg::REQ_CPU_WR, 16'h5FFF, 8'hFF);
      send_word(sbsm_pkg::REQ_CPU_WR, 16'h6000, 8'hA5);
      send_word(sbsm_pkg::REQ_CPU_RD, 16'h6000, 8'h00);
      send_word(sbsm_pkg::REQ_CPU_WR, 16'h7FFF, 8'h5A);
      send_word(sbsm_pkg::REQ_CPU_RD, 16'h7FFF, 8'hFF);
      send_word(sbsm_pkg::REQ_CPU_RD, 16'h8000, 8'h00);
      send_word(sbsm_pkg::REQ_CPU_RD, 16'hFFFF, 8'h00);
      send_word(sbsm_pkg::REQ_CPU_WR, 16'hFFFF, 8'h80);
      serial_load(16'hE000, 5'h10);
      send_word(sbsm_pkg::REQ_CPU_WR, 16'h6001, 8'h77);
      send_word(sbsm_pkg::REQ_CPU_RD, 16'h6001, 8'h00);
      serial_load(16'hE000, 5'h00);
      send_word(sbsm_pkg::REQ_PPU_RD, 16'h0000, 8'h00);
      send_word(sbsm_pkg::REQ_PPU_RD, 16'h1FFF, 8'h00);
      send_word(sbsm_pkg::REQ_PPU_RD, 16'hFFFF, 8'h00);
      send_word(sbsm_pkg::REQ_PPU_WR, 16'h0010, 8'hFF);
      settle_outputs();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: apply_setting(5'd1, 5'd1, 1'b1, 18'd131072, 1'b1);
            1: apply_setting(5'd0, 5'd0, 1'b0, 18'd0, 1'b0);
            2: apply_setting(5'd31, 5'd31, 1'b1, 18'h3FFFF, 1'b1);
            3: apply_setting(5'd16, 5'd16, 1'b1, 18'd131072, 1'b0);
            default: apply_setting(5'($urandom), 5'($urandom), $urandom_range(0, 3) != 0,
                                   ($urandom_range(0, 3) == 0) ?
                                      18'($urandom_range(0, 18'h3FFFF)) :
                                      18'($urandom_range(1, 32) * 32'h1000),
                                   1'($urandom));
         endcase
         if (phase == 2 || phase == 5) long_hold = 1'b1;
         words_sent = 0;
         while (words_sent < PHASE_SIZE) random_burst();
         settle_outputs();
      end

      repeat (20) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sbsm_pkg.sv
rtl/sbsm_wram.sv
rtl/sbsm_rem_unit.sv
rtl/serial_bank_switch_mapper.sv
dv/serial_bank_switch_mapper_tb.sv
